// File: hw/rtl/chgs_pkg.sv
// ----------------------------------------------------------------------------
// Convex hull unit package
// Shared types for the hull sequencer and its turn evaluation unit.
// ----------------------------------------------------------------------------
package chgs_pkg;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'b00,
        SIGN_POS  = 2'b01,
        SIGN_NEG  = 2'b11
    } t_sign;

endpackage

// File: hw/rtl/chgs_turn.sv
// ----------------------------------------------------------------------------
// Convex hull turn unit
// Multi-cycle evaluation of the cross product sign of (a - o) x (b - o),
// with one multiplier used for both products.
// It also compares the Manhattan distances of a and b from o.
// ----------------------------------------------------------------------------
module chgs_turn #(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic signed [W-1:0] i_ox,
    input  logic signed [W-1:0] i_oy,
    input  logic signed [W-1:0] i_ax,
    input  logic signed [W-1:0] i_ay,
    input  logic signed [W-1:0] i_bx,
    input  logic signed [W-1:0] i_by,
    output logic                o_done,
    output chgs_pkg::t_sign     o_sign,
    output logic                o_a_nearer
);

    localparam int DW = W + 1;
    localparam int PW = 2 * DW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL1,
        S_MUL2,
        S_CMP
    } t_state;

    t_state                  r_state;
    logic signed [DW-1:0]    r_ax, r_ay, r_bx, r_by;
    logic signed [PW-1:0]    r_p, r_q;
    logic                    r_done;
    chgs_pkg::t_sign         r_sign;
    logic                    r_near;
    logic [DW:0]             w_da, w_db;
    logic signed [DW-1:0]    w_ma, w_mb;
    logic signed [PW-1:0]    w_prod;

    function automatic logic [DW-1:0] f_abs(input logic signed [DW-1:0] v);
        f_abs = v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    assign w_da = (DW+1)'(f_abs(r_ax)) + (DW+1)'(f_abs(r_ay));
    assign w_db = (DW+1)'(f_abs(r_bx)) + (DW+1)'(f_abs(r_by));

    assign w_ma   = (r_state == S_MUL1) ? r_ax : r_ay;
    assign w_mb   = (r_state == S_MUL1) ? r_by : r_bx;
    assign w_prod = PW'(w_ma) * PW'(w_mb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_ax    <= DW'(i_ax) - DW'(i_ox);
                    r_ay    <= DW'(i_ay) - DW'(i_oy);
                    r_bx    <= DW'(i_bx) - DW'(i_ox);
                    r_by    <= DW'(i_by) - DW'(i_oy);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p     <= w_prod;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_q     <= w_prod;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_p > r_q) begin
                        r_sign <= chgs_pkg::SIGN_POS;
                    end else if (r_p < r_q) begin
                        r_sign <= chgs_pkg::SIGN_NEG;
                    end else begin
                        r_sign <= chgs_pkg::SIGN_ZERO;
                    end
                    r_near  <= w_da < w_db;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_sign     = r_sign;
    assign o_a_nearer = r_near;

endmodule

// File: hw/rtl/convex_hull_graham_scan_unit.sv
// ----------------------------------------------------------------------------
// Convex hull Graham scan unit
// Loads points, then sorts them by angle about the pivot, removes duplicates
// and emits the hull vertices counter-clockwise from the pivot.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Fields
// point     in         i_start, o_busy      i_x, i_y, i_last_point
// hull      out        o_valid strobe       o_hull_x, o_hull_y, o_hull_last,
//                                           o_hull_count, o_overflowed
//
// Loading stores each point as it is offered and tracks the pivot. The closing
// point starts a pivot swap, an insertion sort in which each compare may be
// followed by a swap, a duplicate pass over the sorted points and the stack
// scan, all around one shared turn unit. Each vertex is read from the stack
// and then emitted. Reset is synchronous and clears control state. The
// receiver cannot stall; o_busy falls in the cycle that carries the last
// vertex.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan_unit #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_x,
    input  logic [15:0] i_y,
    input  logic        i_last_point,
    output logic        o_valid,
    output logic [15:0] o_hull_x,
    output logic [15:0] o_hull_y,
    output logic        o_hull_last,
    output logic [6:0]  o_hull_count,
    output logic        o_overflowed
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int W  = COORD_BITS;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PIVSWAP,
        S_SORT_RD,
        S_SORT_WAIT,
        S_SORT_SWAP,
        S_DUP_RD,
        S_DUP_WR,
        S_SCAN_LD,
        S_SCAN_CHK,
        S_SCAN_WAIT,
        S_POP_PX,
        S_SCAN_PUSH,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic signed [W-1:0] r_px [MAX_POINTS];
    logic signed [W-1:0] r_py [MAX_POINTS];
    logic [AW-1:0]       r_stk [MAX_POINTS];
    logic [CW-1:0]       r_cnt;
    logic                r_ovf;
    logic [CW-1:0]       r_i, r_j, r_m, r_top, r_k;
    logic [AW-1:0]       r_piv, r_sidx;
    logic signed [W-1:0] r_pvx, r_pvy, r_fx, r_fy, r_lx, r_ly;
    logic signed [W-1:0] r_t1x, r_t1y, r_t2x, r_t2y;
    logic                r_go;
    logic signed [W-1:0] r_ox, r_oy, r_ax, r_ay, r_bx, r_by;
    logic                r_valid;
    logic [15:0]         r_hx, r_hy;
    logic                r_hlast;
    logic [6:0]          r_hcnt;
    logic                r_hovf;

    logic                w_done;
    chgs_pkg::t_sign     w_sign;
    logic                w_near;
    logic signed [W-1:0] w_x, w_y;

    assign w_x = W'(i_x);
    assign w_y = W'(i_y);

    chgs_turn #(.W(W)) u_turn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (r_go),
        .i_ox       (r_ox),
        .i_oy       (r_oy),
        .i_ax       (r_ax),
        .i_ay       (r_ay),
        .i_bx       (r_bx),
        .i_by       (r_by),
        .o_done     (w_done),
        .o_sign     (w_sign),
        .o_a_nearer (w_near)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_go    <= 1'b0;
            r_valid <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (i_start) begin
                        if (r_cnt < CW'(MAX_POINTS)) begin
                            r_px[r_cnt[AW-1:0]] <= w_x;
                            r_py[r_cnt[AW-1:0]] <= w_y;
                            r_cnt <= r_cnt + CW'(1);
                            if (r_cnt == '0) begin
                                r_fx  <= w_x;
                                r_fy  <= w_y;
                                r_pvx <= w_x;
                                r_pvy <= w_y;
                                r_piv <= '0;
                            end else if (w_y < r_pvy || (w_y == r_pvy && w_x < r_pvx)) begin
                                r_pvx <= w_x;
                                r_pvy <= w_y;
                                r_piv <= r_cnt[AW-1:0];
                            end
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_point) begin
                            r_state <= S_PIVSWAP;
                        end
                    end
                end
                S_PIVSWAP: begin
                    if (r_piv != '0) begin
                        r_px[0]     <= r_pvx;
                        r_py[0]     <= r_pvy;
                        r_px[r_piv] <= r_fx;
                        r_py[r_piv] <= r_fy;
                    end
                    r_i     <= CW'(2);
                    r_j     <= CW'(2);
                    r_state <= S_SORT_RD;
                end
                S_SORT_RD: begin
                    if (r_i >= r_cnt) begin
                        r_i     <= '0;
                        r_m     <= '0;
                        r_state <= S_DUP_RD;
                    end else if (r_j <= CW'(1)) begin
                        r_i <= r_i + CW'(1);
                        r_j <= r_i + CW'(1);
                    end else begin
                        r_ox    <= r_pvx;
                        r_oy    <= r_pvy;
                        r_ax    <= r_px[r_j[AW-1:0]];
                        r_ay    <= r_py[r_j[AW-1:0]];
                        r_bx    <= r_px[AW'(r_j - CW'(1))];
                        r_by    <= r_py[AW'(r_j - CW'(1))];
                        r_go    <= 1'b1;
                        r_state <= S_SORT_WAIT;
                    end
                end
                S_SORT_WAIT: begin
                    if (w_done) begin
                        if (w_sign == chgs_pkg::SIGN_POS ||
                            (w_sign == chgs_pkg::SIGN_ZERO && w_near)) begin
                            r_state <= S_SORT_SWAP;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_j     <= r_i + CW'(1);
                            r_state <= S_SORT_RD;
                        end
                    end
                end
                S_SORT_SWAP: begin
                    r_px[r_j[AW-1:0]]       <= r_bx;
                    r_py[r_j[AW-1:0]]       <= r_by;
                    r_px[AW'(r_j - CW'(1))] <= r_ax;
                    r_py[AW'(r_j - CW'(1))] <= r_ay;
                    r_j                     <= r_j - CW'(1);
                    r_state                 <= S_SORT_RD;
                end
                S_DUP_RD: begin
                    if (r_i < r_cnt) begin
                        r_ax    <= r_px[r_i[AW-1:0]];
                        r_ay    <= r_py[r_i[AW-1:0]];
                        r_state <= S_DUP_WR;
                    end else begin
                        r_top   <= '0;
                        r_i     <= '0;
                        r_state <= S_SCAN_LD;
                    end
                end
                S_DUP_WR: begin
                    if (r_m == '0 || r_ax != r_lx || r_ay != r_ly) begin
                        r_px[r_m[AW-1:0]] <= r_ax;
                        r_py[r_m[AW-1:0]] <= r_ay;
                        r_lx              <= r_ax;
                        r_ly              <= r_ay;
                        r_m               <= r_m + CW'(1);
                    end
                    r_i     <= r_i + CW'(1);
                    r_state <= S_DUP_RD;
                end
                S_SCAN_LD: begin
                    if (r_i >= r_m) begin
                        r_k     <= '0;
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_bx    <= r_px[r_i[AW-1:0]];
                        r_by    <= r_py[r_i[AW-1:0]];
                        r_state <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    if (r_top < CW'(2)) begin
                        r_state <= S_SCAN_PUSH;
                    end else begin
                        r_ox    <= r_t2x;
                        r_oy    <= r_t2y;
                        r_ax    <= r_t1x;
                        r_ay    <= r_t1y;
                        r_go    <= 1'b1;
                        r_state <= S_SCAN_WAIT;
                    end
                end
                S_SCAN_WAIT: begin
                    if (w_done) begin
                        if (w_sign != chgs_pkg::SIGN_POS) begin
                            r_top <= r_top - CW'(1);
                            r_t1x <= r_t2x;
                            r_t1y <= r_t2y;
                            if (r_top >= CW'(3)) begin
                                r_sidx  <= r_stk[AW'(r_top - CW'(3))];
                                r_state <= S_POP_PX;
                            end else begin
                                r_state <= S_SCAN_CHK;
                            end
                        end else begin
                            r_state <= S_SCAN_PUSH;
                        end
                    end
                end
                S_POP_PX: begin
                    r_t2x   <= r_px[r_sidx];
                    r_t2y   <= r_py[r_sidx];
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_PUSH: begin
                    r_stk[r_top[AW-1:0]] <= r_i[AW-1:0];
                    r_top                <= r_top + CW'(1);
                    r_t2x                <= r_t1x;
                    r_t2y                <= r_t1y;
                    r_t1x                <= r_bx;
                    r_t1y                <= r_by;
                    r_i                  <= r_i + CW'(1);
                    r_state              <= S_SCAN_LD;
                end
                S_EMIT_RD: begin
                    r_sidx  <= r_stk[r_k[AW-1:0]];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_valid <= 1'b1;
                    r_hx    <= 16'(r_px[r_sidx]);
                    r_hy    <= 16'(r_py[r_sidx]);
                    r_hlast <= (r_k + CW'(1)) == r_top;
                    r_hcnt  <= 7'(r_top);
                    r_hovf  <= r_ovf;
                    r_k     <= r_k + CW'(1);
                    if ((r_k + CW'(1)) == r_top) begin
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_EMIT_RD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_busy       = (r_state != S_LOAD);
    assign o_valid      = r_valid;
    assign o_hull_x     = r_hx;
    assign o_hull_y     = r_hy;
    assign o_hull_last  = r_hlast;
    assign o_hull_count = r_hcnt;
    assign o_overflowed = r_hovf;

endmodule
